### rtl/twoh_pkg.sv
// Shared types, codes and default sizes of the timing wheel scheduler.
package twoh_pkg;

   // default sizes, handed down to the top level parameters
   localparam int WHEEL_SLOTS_DEF   = 256;
   localparam int SLOT_CAPACITY_DEF = 16;
   localparam int HEAP_CAPACITY_DEF = 256;
   localparam int HANDLE_BITS_DEF   = 16;

   // at most this many handles leave the wheel on one tick
   localparam int MAX_OUT = 16;

   // port field widths
   localparam int CMD_W      = 1;
   localparam int DELAY_W    = 24;
   localparam int HANDLE_W   = 16;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int TICK_W     = 32;
   localparam int WLEN_W     = 9;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [WLEN_W-1:0] WHEEL_LENGTH_RESET = 9'd256;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK     = 1'b1;

   // result kind codes
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DUE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

   // schedule status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SLOT_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HEAP_FULL = 2'd2;

   // one classified request as it waits in the queue
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic                near;
      logic [DELAY_W-1:0]  delay;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   // back part status and handshake toward the front part
   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

   // back part sequencer
   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_CNT_RD,
      S_PUSH,
      S_ACK,
      S_UP_CHK,
      S_UP_CMP,
      S_T_CLR,
      S_M_RD,
      S_M_CHK,
      S_POP,
      S_POP_LD,
      S_DN_L,
      S_DN_R,
      S_DN_CMP,
      S_T_FIN,
      S_EMPTY,
      S_E_RD,
      S_E_OUT
   } state_type;

endpackage

### rtl/twoh_front.sv
// Front part: length register, request classification and request queue.
module twoh_front #(
   parameter int WHEEL_SLOTS = twoh_pkg::WHEEL_SLOTS_DEF,
   parameter int LEN_W       = $clog2(WHEEL_SLOTS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [twoh_pkg::CMD_W-1:0]    req_cmd,
   input  logic [twoh_pkg::DELAY_W-1:0]  req_delay,
   input  logic [twoh_pkg::HANDLE_W-1:0] req_handle,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [twoh_pkg::WLEN_W-1:0]   csr_wheel_length,
   output logic [LEN_W-1:0]             len,
   output logic                         q_valid,
   output twoh_pkg::req_type            q_req,
   input  twoh_pkg::back_status_type    back_status
);
   import twoh_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WLEN_W-1:0] wheel_length_ff, wheel_length_in;
   logic [31:0]       wl32;
   req_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop, full;
   req_type           req;

   // take length writes at any time
   assign csr_ready = 1'b1;
   always_comb begin
      wheel_length_in = wheel_length_ff;
      if (csr_valid && csr_ready) begin
         wheel_length_in = csr_wheel_length;
      end
   end

   // clamp the length into the supported span
   always_comb begin
      wl32 = 32'(wheel_length_ff);
      if (wl32 < 32'd2) begin
         len = LEN_W'(2);
      end else if (wl32 > 32'(WHEEL_SLOTS)) begin
         len = LEN_W'(WHEEL_SLOTS);
      end else begin
         len = LEN_W'(wl32);
      end
   end

   // classify the incoming request
   always_comb begin
      req.cmd    = req_cmd;
      req.near   = (32'(req_delay) < 32'(len));
      req.delay  = req_delay;
      req.handle = req_handle;
   end

   // queue control
   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign busy    = full || back_status.clearing;
   assign push    = start && !busy;
   assign pop     = back_status.pop && q_valid;
   assign q_valid = (count_ff != '0);
   assign q_req   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_length_ff <= WHEEL_LENGTH_RESET;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         wheel_length_ff <= wheel_length_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   // hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req;
      end
   end

endmodule

### rtl/twoh_back.sv
// Back part: wheel slots, overflow heap and the sequencer that runs requests.
module twoh_back #(
   parameter int WHEEL_SLOTS   = twoh_pkg::WHEEL_SLOTS_DEF,
   parameter int SLOT_CAPACITY = twoh_pkg::SLOT_CAPACITY_DEF,
   parameter int HEAP_CAPACITY = twoh_pkg::HEAP_CAPACITY_DEF,
   parameter int HANDLE_BITS   = twoh_pkg::HANDLE_BITS_DEF,
   parameter int LEN_W         = $clog2(WHEEL_SLOTS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [LEN_W-1:0]              len,
   input  logic                          q_valid,
   input  twoh_pkg::req_type             q_req,
   output twoh_pkg::back_status_type     back_status,
   output logic                          rsp_strobe,
   output logic [twoh_pkg::KIND_W-1:0]   rsp_kind,
   output logic [twoh_pkg::HANDLE_W-1:0] rsp_due_handle,
   output logic                          rsp_last_of_tick,
   output logic [twoh_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_dropped_sticky,
   output logic [twoh_pkg::TICK_W-1:0]   rsp_now_ticks
);
   import twoh_pkg::*;

   localparam int POS_W  = $clog2(WHEEL_SLOTS);
   localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);
   localparam int SA_W   = $clog2(WHEEL_SLOTS * SLOT_CAPACITY);
   localparam int HI_W   = $clog2(HEAP_CAPACITY);
   localparam int HS_W   = $clog2(HEAP_CAPACITY + 1);
   localparam int CH_W   = HI_W + 2;
   localparam int HE_W   = TICK_W + HANDLE_BITS;
   localparam int MOD_W  = $clog2(2 * WHEEL_SLOTS);
   localparam int MC_W   = $clog2(MOD_W);
   localparam int EMIT_W = $clog2(MAX_OUT + 1);

   // memories
   logic [HANDLE_BITS-1:0] slot_mem [WHEEL_SLOTS * SLOT_CAPACITY];
   logic [CNT_W-1:0]       cnt_mem  [WHEEL_SLOTS];
   logic [HE_W-1:0]        heap_mem [HEAP_CAPACITY];
   logic [HANDLE_BITS-1:0] slot_q;
   logic [CNT_W-1:0]       cnt_q;
   logic [HE_W-1:0]        heap_q;

   logic                   slot_we;
   logic [SA_W-1:0]        slot_waddr, slot_raddr;
   logic [HANDLE_BITS-1:0] slot_wdata;
   logic                   cnt_we;
   logic [POS_W-1:0]       cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]       cnt_wdata;
   logic                   heap_we;
   logic [HI_W-1:0]        heap_waddr, heap_raddr;
   logic [HE_W-1:0]        heap_wdata;

   // control and working registers
   state_type              state_ff, state_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [HS_W-1:0]        size_ff, size_in;
   logic                   drop_ff, drop_in;
   logic [POS_W-1:0]       clr_ff, clr_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   migr_ff, migr_in;
   logic [MOD_W-1:0]       mod_val_ff, mod_val_in;
   logic [LEN_W-1:0]       mod_rem_ff, mod_rem_in;
   logic [MC_W-1:0]        mod_cnt_ff, mod_cnt_in;
   logic [POS_W-1:0]       slot_ff, slot_in;
   logic [HANDLE_BITS-1:0] push_h_ff, push_h_in;
   logic [HE_W-1:0]        x_ff, x_in;
   logic [HE_W-1:0]        cl_ff, cl_in;
   logic [HI_W-1:0]        hole_ff, hole_in;
   logic [HI_W-1:0]        par_ff, par_in;
   logic                   r_ok_ff, r_ok_in;
   logic [CNT_W-1:0]       old_cnt_ff, old_cnt_in;
   logic [POS_W-1:0]       old_pos_ff, old_pos_in;
   logic [EMIT_W-1:0]      emit_left_ff, emit_left_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;

   logic [LEN_W:0]         mod_t;
   logic [POS_W:0]         pos_next;
   logic [TICK_W-1:0]      diff;
   logic [MOD_W-1:0]       d_off;
   logic [CH_W-1:0]        lchild, rchild;
   logic [HE_W-1:0]        best;
   logic [HI_W-1:0]        best_idx;
   logic [HS_W-1:0]        size_dec;

   // wrap-safe ordering key of a heap entry
   function automatic logic [TICK_W-1:0] heap_key(input logic [HE_W-1:0] e,
                                                  input logic [TICK_W-1:0] now);
      return e[HE_W-1:HANDLE_BITS] - now;
   endfunction

   assign back_status.clearing = (state_ff == S_CLEAR);
   assign back_status.pop      = (state_ff == S_IDLE) && q_valid;

   // helper terms for the sequencer
   always_comb begin
      mod_t = {mod_rem_ff, mod_val_ff[MOD_W-1]};
      if (mod_t >= (LEN_W + 1)'(len)) begin
         mod_t = mod_t - (LEN_W + 1)'(len);
      end
      pos_next = (POS_W + 1)'(pos_ff) + 1'b1;
      if (pos_next >= (POS_W + 1)'(len)) begin
         pos_next = '0;
      end
      diff = heap_key(heap_q, tick_ff);
      if (diff[TICK_W-1] || diff == '0) begin
         d_off = '0;
      end else begin
         d_off = MOD_W'(diff - 1'b1);
      end
      lchild   = {1'b0, hole_ff, 1'b1};
      rchild   = lchild + 1'b1;
      size_dec = size_ff - 1'b1;
      best     = x_ff;
      best_idx = hole_ff;
      if (heap_key(cl_ff, tick_ff) < heap_key(best, tick_ff)) begin
         best     = cl_ff;
         best_idx = HI_W'(lchild);
      end
      if (r_ok_ff && heap_key(heap_q, tick_ff) < heap_key(best, tick_ff)) begin
         best     = heap_q;
         best_idx = HI_W'(rchild);
      end
   end

   // sequencer: next state, memory ports and results
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      pos_in       = pos_ff;
      size_in      = size_ff;
      drop_in      = drop_ff;
      clr_in       = clr_ff;
      status_in    = status_ff;
      migr_in      = migr_ff;
      mod_val_in   = mod_val_ff;
      mod_rem_in   = mod_rem_ff;
      mod_cnt_in   = mod_cnt_ff;
      slot_in      = slot_ff;
      push_h_in    = push_h_ff;
      x_in         = x_ff;
      cl_in        = cl_ff;
      hole_in      = hole_ff;
      par_in       = par_ff;
      r_ok_in      = r_ok_ff;
      old_cnt_in   = old_cnt_ff;
      old_pos_in   = old_pos_ff;
      emit_left_in = emit_left_ff;
      rd_idx_in    = rd_idx_ff;

      slot_we    = 1'b0;
      slot_waddr = SA_W'(slot_ff) * SA_W'(SLOT_CAPACITY) + SA_W'(cnt_q);
      slot_wdata = push_h_ff;
      slot_raddr = SA_W'(old_pos_ff) * SA_W'(SLOT_CAPACITY) + SA_W'(rd_idx_ff);
      cnt_we     = 1'b0;
      cnt_waddr  = slot_ff;
      cnt_wdata  = cnt_q + 1'b1;
      cnt_raddr  = pos_ff;
      heap_we    = 1'b0;
      heap_waddr = hole_ff;
      heap_wdata = x_ff;
      heap_raddr = '0;

      rsp_strobe       = 1'b0;
      rsp_kind         = KIND_ACK;
      rsp_due_handle   = '0;
      rsp_last_of_tick = 1'b1;
      rsp_status       = STATUS_OK;

      case (state_ff)
         // zero every slot count after reset
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == POS_W'(WHEEL_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         // take the next request from the queue
         S_IDLE: begin
            if (q_valid) begin
               status_in = STATUS_OK;
               push_h_in = HANDLE_BITS'(32'(q_req.handle));
               if (q_req.cmd == CMD_TICK) begin
                  state_in = S_T_CLR;
               end else if (q_req.near) begin
                  migr_in    = 1'b0;
                  mod_val_in = MOD_W'(pos_ff) + MOD_W'(q_req.delay);
                  mod_rem_in = '0;
                  mod_cnt_in = MC_W'(MOD_W - 1);
                  state_in   = S_MOD;
               end else if (size_ff == HS_W'(HEAP_CAPACITY)) begin
                  drop_in   = 1'b1;
                  status_in = STATUS_HEAP_FULL;
                  state_in  = S_ACK;
               end else begin
                  x_in     = {tick_ff + TICK_W'(q_req.delay),
                              HANDLE_BITS'(32'(q_req.handle))};
                  hole_in  = HI_W'(size_ff);
                  size_in  = size_ff + 1'b1;
                  state_in = S_UP_CHK;
               end
            end
         end
         // reduce the slot index by the length, one bit a cycle
         S_MOD: begin
            mod_rem_in = mod_t[LEN_W-1:0];
            mod_val_in = mod_val_ff << 1;
            mod_cnt_in = mod_cnt_ff - 1'b1;
            if (mod_cnt_ff == '0) begin
               slot_in  = POS_W'(mod_t[LEN_W-1:0]);
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            cnt_raddr = slot_ff;
            state_in  = S_PUSH;
         end
         // append the handle to its slot or drop it
         S_PUSH: begin
            if (cnt_q >= CNT_W'(SLOT_CAPACITY)) begin
               drop_in   = 1'b1;
               status_in = STATUS_SLOT_FULL;
            end else begin
               slot_we = 1'b1;
               cnt_we  = 1'b1;
            end
            state_in = migr_ff ? S_POP : S_ACK;
         end
         S_ACK: begin
            rsp_strobe = 1'b1;
            rsp_kind   = KIND_ACK;
            rsp_status = status_ff;
            state_in   = S_IDLE;
         end
         // sift the new heap entry up
         S_UP_CHK: begin
            if (hole_ff == '0) begin
               heap_we  = 1'b1;
               state_in = S_ACK;
            end else begin
               par_in     = (hole_ff - 1'b1) >> 1;
               heap_raddr = (hole_ff - 1'b1) >> 1;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            heap_we = 1'b1;
            if (heap_key(x_ff, tick_ff) < heap_key(heap_q, tick_ff)) begin
               heap_wdata = heap_q;
               hole_in    = par_ff;
               state_in   = S_UP_CHK;
            end else begin
               state_in = S_ACK;
            end
         end
         // drop the current slot and step the position
         S_T_CLR: begin
            old_cnt_in = cnt_q;
            old_pos_in = pos_ff;
            cnt_we     = 1'b1;
            cnt_waddr  = pos_ff;
            cnt_wdata  = '0;
            pos_in     = POS_W'(pos_next);
            migr_in    = 1'b1;
            state_in   = S_M_RD;
         end
         S_M_RD: begin
            heap_raddr = '0;
            state_in   = (size_ff == '0) ? S_T_FIN : S_M_CHK;
         end
         // move the heap root into the wheel if it is near enough
         S_M_CHK: begin
            if (diff[TICK_W-1] || diff < TICK_W'(len)) begin
               push_h_in  = heap_q[HANDLE_BITS-1:0];
               mod_val_in = MOD_W'(pos_ff) + d_off;
               mod_rem_in = '0;
               mod_cnt_in = MC_W'(MOD_W - 1);
               state_in   = S_MOD;
            end else begin
               state_in = S_T_FIN;
            end
         end
         // remove the root and refill it with the last entry
         S_POP: begin
            size_in    = size_dec;
            heap_raddr = HI_W'(size_dec);
            state_in   = (size_dec == '0) ? S_M_RD : S_POP_LD;
         end
         S_POP_LD: begin
            x_in     = heap_q;
            hole_in  = '0;
            state_in = S_DN_L;
         end
         // sift the moved entry down
         S_DN_L: begin
            if (lchild >= CH_W'(size_ff)) begin
               heap_we  = 1'b1;
               state_in = S_M_RD;
            end else begin
               heap_raddr = HI_W'(lchild);
               state_in   = S_DN_R;
            end
         end
         S_DN_R: begin
            cl_in      = heap_q;
            r_ok_in    = (rchild < CH_W'(size_ff));
            heap_raddr = HI_W'(rchild);
            state_in   = S_DN_CMP;
         end
         S_DN_CMP: begin
            heap_we = 1'b1;
            if (best_idx == hole_ff) begin
               state_in = S_M_RD;
            end else begin
               heap_wdata = best;
               hole_in    = best_idx;
               state_in   = S_DN_L;
            end
         end
         // advance time and start the emission of the old slot or of the empty marker
         S_T_FIN: begin
            tick_in = tick_ff + 1'b1;
            if (old_cnt_ff == '0) begin
               state_in = S_EMPTY;
            end else begin
               emit_left_in = (32'(old_cnt_ff) > 32'(MAX_OUT)) ? EMIT_W'(MAX_OUT)
                                                               : EMIT_W'(old_cnt_ff);
               rd_idx_in    = old_cnt_ff - 1'b1;
               state_in     = S_E_RD;
            end
         end
         S_EMPTY: begin
            rsp_strobe = 1'b1;
            rsp_kind   = KIND_EMPTY;
            state_in   = S_IDLE;
         end
         S_E_RD: begin
            state_in = S_E_OUT;
         end
         S_E_OUT: begin
            rsp_strobe       = 1'b1;
            rsp_kind         = KIND_DUE;
            rsp_due_handle   = HANDLE_W'(32'(slot_q));
            rsp_last_of_tick = (emit_left_ff == EMIT_W'(1));
            emit_left_in     = emit_left_ff - 1'b1;
            rd_idx_in        = rd_idx_ff - 1'b1;
            state_in         = (emit_left_ff == EMIT_W'(1)) ? S_IDLE : S_E_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_dropped_sticky = drop_ff;
   assign rsp_now_ticks      = tick_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         tick_ff  <= '0;
         pos_ff   <= '0;
         size_ff  <= '0;
         drop_ff  <= 1'b0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         pos_ff   <= pos_in;
         size_ff  <= size_in;
         drop_ff  <= drop_in;
         clr_ff   <= clr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      migr_ff      <= migr_in;
      mod_val_ff   <= mod_val_in;
      mod_rem_ff   <= mod_rem_in;
      mod_cnt_ff   <= mod_cnt_in;
      slot_ff      <= slot_in;
      push_h_ff    <= push_h_in;
      x_ff         <= x_in;
      cl_ff        <= cl_in;
      hole_ff      <= hole_in;
      par_ff       <= par_in;
      r_ok_ff      <= r_ok_in;
      old_cnt_ff   <= old_cnt_in;
      old_pos_ff   <= old_pos_in;
      emit_left_ff <= emit_left_in;
      rd_idx_ff    <= rd_idx_in;
   end

   // slot handle memory
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_q <= slot_mem[slot_raddr];
   end

   // slot count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_q <= cnt_mem[cnt_raddr];
   end

   // heap memory
   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_waddr] <= heap_wdata;
      end
      heap_q <= heap_mem[heap_raddr];
   end

`ifndef ASSERT_OFF
   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= HS_W'(HEAP_CAPACITY))
      else $error("heap size beyond capacity");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T_FIN) |=> (tick_ff == $past(tick_ff) + 1'b1))
      else $error("tick did not advance by one");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_of_tick) |=> !rsp_strobe)
      else $error("result follows the last result of a request");
`endif

endmodule

### rtl/timing_wheel_with_overflow_heap.sv
// Top level of the timing wheel scheduler with overflow heap.
//
// Requests enter on start/busy: a request is taken at a clock edge with
// start high and busy low. req_cmd selects schedule (req_delay, req_handle)
// or tick. Two requests queue in front of the executor.
// Results leave on rsp_strobe, one cycle each, with no stall from the
// receiver. A schedule gives one acknowledge; a tick gives its due handles,
// newest first, or one empty marker, the final one flagged last_of_tick.
// A near schedule reduces its slot index by the length bit by bit; a far
// schedule sifts its heap entry up, one level at a time. A tick clears the
// current slot, steps the position, moves each heap root that is near enough
// into the wheel and sifts the heap down after each, then advances time and
// gives the empty marker or the due handles.
// Length writes on csr_valid/csr_ready are always taken; write only while idle.
// After reset the slot counts are cleared one by one, with busy
// high; time, position, heap size and the drop flag start at zero.
module timing_wheel_with_overflow_heap #(
   parameter int WHEEL_SLOTS   = twoh_pkg::WHEEL_SLOTS_DEF,
   parameter int SLOT_CAPACITY = twoh_pkg::SLOT_CAPACITY_DEF,
   parameter int HEAP_CAPACITY = twoh_pkg::HEAP_CAPACITY_DEF,
   parameter int HANDLE_BITS   = twoh_pkg::HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [twoh_pkg::CMD_W-1:0]    req_cmd,
   input  logic [twoh_pkg::DELAY_W-1:0]  req_delay,
   input  logic [twoh_pkg::HANDLE_W-1:0] req_handle,
   output logic                          rsp_strobe,
   output logic [twoh_pkg::KIND_W-1:0]   rsp_kind,
   output logic [twoh_pkg::HANDLE_W-1:0] rsp_due_handle,
   output logic                          rsp_last_of_tick,
   output logic [twoh_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_dropped_sticky,
   output logic [twoh_pkg::TICK_W-1:0]   rsp_now_ticks,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [twoh_pkg::WLEN_W-1:0]   csr_wheel_length
);
   import twoh_pkg::*;

   localparam int LEN_W = $clog2(WHEEL_SLOTS + 1);

   logic [LEN_W-1:0] len;
   logic             q_valid;
   req_type          q_req;
   back_status_type  back_status;

   // accept, classify and queue requests
   twoh_front #(
      .WHEEL_SLOTS (WHEEL_SLOTS),
      .LEN_W       (LEN_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_delay        (req_delay),
      .req_handle       (req_handle),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wheel_length (csr_wheel_length),
      .len              (len),
      .q_valid          (q_valid),
      .q_req            (q_req),
      .back_status      (back_status)
   );

   // run requests against the wheel and heap
   twoh_back #(
      .WHEEL_SLOTS   (WHEEL_SLOTS),
      .SLOT_CAPACITY (SLOT_CAPACITY),
      .HEAP_CAPACITY (HEAP_CAPACITY),
      .HANDLE_BITS   (HANDLE_BITS),
      .LEN_W         (LEN_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .len                (len),
      .q_valid            (q_valid),
      .q_req              (q_req),
      .back_status        (back_status),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_due_handle     (rsp_due_handle),
      .rsp_last_of_tick   (rsp_last_of_tick),
      .rsp_status         (rsp_status),
      .rsp_dropped_sticky (rsp_dropped_sticky),
      .rsp_now_ticks      (rsp_now_ticks)
   );

endmodule
